@@ hw/rtl/nbpcm_pkg.sv @@
package nbpcm_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = IDX_W + 1;
	localparam int CHAN_W      = 8;
	localparam int COLOUR_W    = 3 * CHAN_W;
	localparam int LIMIT_W     = 18;
	localparam int ENTRIES_W   = 5;
	localparam int METRIC_W    = 20;
	localparam int SQ_W        = 2 * CHAN_W;
	localparam int PROD_W      = 26;
	localparam int TERM_W      = PROD_W - 8;

	localparam logic [9:0] RED_BASE  = 10'd512;
	localparam logic [9:0] BLUE_BASE = 10'd767;

	localparam logic [LIMIT_W-1:0]   PAIR_LIMIT_RST = 18'd14400;
	localparam logic [ENTRIES_W-1:0] ENTRIES_RST    = 5'd15;

	localparam logic REG_PAIR_LIMIT = 1'b0;
	localparam logic REG_ENTRIES    = 1'b1;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_MATCH = 1'b1;

	typedef struct packed {
		logic             start;
		logic             wr_en;
		logic             issue;
		logic             load_out;
		logic [IDX_W-1:0] rd_x;
		logic [IDX_W-1:0] rd_y;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} status_t;

endpackage

@@ hw/rtl/nbpcm_ram.sv @@
module nbpcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ hw/rtl/nbpcm_ctrl.sv @@
module nbpcm_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [nbpcm_pkg::IDX_W-1:0]       entry_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	input  logic [nbpcm_pkg::ENTRIES_W-1:0]   entries_in_use,
	input  nbpcm_pkg::status_t                status,
	output nbpcm_pkg::cmd_t                   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                           state_q;
	logic [nbpcm_pkg::IDX_W-1:0]      x_q;
	logic [nbpcm_pkg::IDX_W-1:0]      y_q;
	logic [nbpcm_pkg::CNT_W-1:0]      last_q;
	logic                             out_valid_q;
	logic                             accept;
	logic                             last_pair;
	logic                             out_free;
	logic [nbpcm_pkg::CNT_W-1:0]      n_sat;
	logic                             idx_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign last_pair = ({1'b0, x_q} == last_q) && ({1'b0, y_q} == last_q);
	assign idx_ok    = {1'b0, entry_index} < nbpcm_pkg::CNT_W'(nbpcm_pkg::MAX_ENTRIES);

	always_comb begin
		if (nbpcm_pkg::CNT_W'(entries_in_use) > nbpcm_pkg::CNT_W'(nbpcm_pkg::MAX_ENTRIES)) begin
			n_sat = nbpcm_pkg::CNT_W'(nbpcm_pkg::MAX_ENTRIES);
		end else begin
			n_sat = nbpcm_pkg::CNT_W'(entries_in_use);
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_x     = x_q;
		cmd.rd_y     = y_q;
		cmd.wr_en    = accept && (func == nbpcm_pkg::FUNC_LOAD) && idx_ok;
		cmd.start    = accept && (func == nbpcm_pkg::FUNC_MATCH);
		cmd.issue    = (state_q == ST_RUN);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (func == nbpcm_pkg::FUNC_MATCH)) begin
						x_q    <= '0;
						y_q    <= '0;
						last_q <= n_sat - 1'b1;
						// nothing to visit with no entries in use
						state_q <= (n_sat == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_pair) begin
						state_q <= ST_DRAIN;
					end else if ({1'b0, y_q} == last_q) begin
						y_q <= '0;
						x_q <= x_q + 1'b1;
					end else begin
						y_q <= y_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!status.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/nbpcm_dp.sv @@
module nbpcm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nbpcm_pkg::cmd_t                   cmd,
	output nbpcm_pkg::status_t                status,
	input  logic [nbpcm_pkg::IDX_W-1:0]       entry_index,
	input  logic [nbpcm_pkg::CHAN_W-1:0]      red,
	input  logic [nbpcm_pkg::CHAN_W-1:0]      green,
	input  logic [nbpcm_pkg::CHAN_W-1:0]      blue,
	input  logic [nbpcm_pkg::LIMIT_W-1:0]     pair_limit_sq,
	output logic [nbpcm_pkg::IDX_W-1:0]       best_first,
	output logic [nbpcm_pkg::IDX_W-1:0]       best_second,
	output logic [nbpcm_pkg::METRIC_W-1:0]    best_metric,
	output logic                              found
);

	localparam int CW = nbpcm_pkg::CHAN_W;
	localparam int IW = nbpcm_pkg::IDX_W;
	localparam int SW = nbpcm_pkg::SQ_W;
	localparam int TW = nbpcm_pkg::TERM_W;
	localparam int MW = nbpcm_pkg::METRIC_W;

	logic [nbpcm_pkg::COLOUR_W-1:0] c1;
	logic [nbpcm_pkg::COLOUR_W-1:0] c2;

	logic [CW-1:0] tgt_r_q, tgt_g_q, tgt_b_q;

	// stage 1: table read data
	logic          v_s1;
	logic [IW-1:0] x_s1, y_s1;

	// stage 2: absolute differences and red mean
	logic          v_s2;
	logic [IW-1:0] x_s2, y_s2;
	logic [CW-1:0] pdr_s2, pdg_s2, pdb_s2;
	logic [CW-1:0] dr_s2, dg_s2, db_s2;
	logic [CW-1:0] rmean_s2;

	// stage 3: squares of kept pairs
	logic          v_s3;
	logic [IW-1:0] x_s3, y_s3;
	logic [SW-1:0] drsq_s3, dgsq_s3, dbsq_s3;
	logic [CW-1:0] rmean_s3;

	// stage 4: weighted terms
	logic          v_s4;
	logic [IW-1:0] x_s4, y_s4;
	logic [TW-1:0] tr_s4, tg_s4, tb_s4;

	logic          found_q;
	logic [MW-1:0] best_q;
	logic [IW-1:0] bf_q, bs_q;

	logic [IW-1:0] res_first_q, res_second_q;
	logic [MW-1:0] res_metric_q;
	logic          res_found_q;

	function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [CW-1:0] avg(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s   = {1'b0, a} + {1'b0, b};
		avg = s[CW:1];
	endfunction

	nbpcm_ram #(
		.WIDTH(nbpcm_pkg::COLOUR_W),
		.DEPTH(nbpcm_pkg::MAX_ENTRIES)
	) u_table (
		.clk     (clk),
		.we      (cmd.wr_en),
		.waddr   (entry_index),
		.wdata   ({red, green, blue}),
		.raddr_a (cmd.rd_x),
		.raddr_b (cmd.rd_y),
		.rdata_a (c1),
		.rdata_b (c2)
	);

	logic [CW-1:0] bl_r, bl_g, bl_b;
	assign bl_r = avg(c1[3*CW-1:2*CW], c2[3*CW-1:2*CW]);
	assign bl_g = avg(c1[2*CW-1:CW],   c2[2*CW-1:CW]);
	assign bl_b = avg(c1[CW-1:0],      c2[CW-1:0]);

	logic [SW-1:0]                    pr_sq, pg_sq, pb_sq;
	logic [nbpcm_pkg::LIMIT_W-1:0]    pd;
	assign pr_sq = pdr_s2 * pdr_s2;
	assign pg_sq = pdg_s2 * pdg_s2;
	assign pb_sq = pdb_s2 * pdb_s2;
	assign pd    = nbpcm_pkg::LIMIT_W'(pr_sq) + nbpcm_pkg::LIMIT_W'(pg_sq)
		+ nbpcm_pkg::LIMIT_W'(pb_sq);

	logic [nbpcm_pkg::PROD_W-1:0] prod_r, prod_b;
	assign prod_r = (nbpcm_pkg::RED_BASE + 10'(rmean_s3)) * drsq_s3;
	assign prod_b = (nbpcm_pkg::BLUE_BASE - 10'(rmean_s3)) * dbsq_s3;

	logic [MW-1:0] metric;
	assign metric = MW'(tr_s4) + MW'(tg_s4) + MW'(tb_s4);

	assign status.busy = v_s1 || v_s2 || v_s3 || v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (pd <= pair_limit_sq);
			v_s4 <= v_s3;
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (v_s4 && (!found_q || metric < best_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tgt_r_q <= red;
			tgt_g_q <= green;
			tgt_b_q <= blue;
			best_q  <= '0;
			bf_q    <= '0;
			bs_q    <= '0;
		end else if (v_s4 && (!found_q || metric < best_q)) begin
			best_q <= metric;
			bf_q   <= x_s4;
			bs_q   <= y_s4;
		end

		x_s1 <= cmd.rd_x;
		y_s1 <= cmd.rd_y;

		x_s2     <= x_s1;
		y_s2     <= y_s1;
		pdr_s2   <= absdiff(c1[3*CW-1:2*CW], c2[3*CW-1:2*CW]);
		pdg_s2   <= absdiff(c1[2*CW-1:CW],   c2[2*CW-1:CW]);
		pdb_s2   <= absdiff(c1[CW-1:0],      c2[CW-1:0]);
		dr_s2    <= absdiff(bl_r, tgt_r_q);
		dg_s2    <= absdiff(bl_g, tgt_g_q);
		db_s2    <= absdiff(bl_b, tgt_b_q);
		rmean_s2 <= avg(bl_r, tgt_r_q);

		x_s3     <= x_s2;
		y_s3     <= y_s2;
		drsq_s3  <= dr_s2 * dr_s2;
		dgsq_s3  <= dg_s2 * dg_s2;
		dbsq_s3  <= db_s2 * db_s2;
		rmean_s3 <= rmean_s2;

		x_s4  <= x_s3;
		y_s4  <= y_s3;
		tr_s4 <= prod_r[nbpcm_pkg::PROD_W-1:8];
		tg_s4 <= {dgsq_s3, 2'b00};
		tb_s4 <= prod_b[nbpcm_pkg::PROD_W-1:8];

		if (cmd.load_out) begin
			res_first_q  <= bf_q;
			res_second_q <= bs_q;
			res_metric_q <= best_q;
			res_found_q  <= found_q;
		end
	end

	assign best_first  = res_first_q;
	assign best_second = res_second_q;
	assign best_metric = res_metric_q;
	assign found       = res_found_q;

endmodule

@@ hw/rtl/nearest_blended_pair_colour_match_unit.sv @@
// Load request: taken while idle, no result; n = entries in use, at most 16.
// Match request: visits all n*n ordered pairs, one pair per cycle, then drains the pipeline;
// with no entries in use it goes straight to draining and reports no pair found.
// One match is in flight at a time; the next request is taken once the result is registered,
// which waits while the previous result is held back by out_ready.
// Reset sets pair_limit_sq to 14400 and entries_in_use to 15; the colour table has no reset.
module nearest_blended_pair_colour_match_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [nbpcm_pkg::IDX_W-1:0]       entry_index,
	input  logic [nbpcm_pkg::CHAN_W-1:0]      red,
	input  logic [nbpcm_pkg::CHAN_W-1:0]      green,
	input  logic [nbpcm_pkg::CHAN_W-1:0]      blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nbpcm_pkg::IDX_W-1:0]       best_first,
	output logic [nbpcm_pkg::IDX_W-1:0]       best_second,
	output logic [nbpcm_pkg::METRIC_W-1:0]    best_metric,
	output logic                              found
);

	logic [nbpcm_pkg::LIMIT_W-1:0]   pair_limit_q;
	logic [nbpcm_pkg::ENTRIES_W-1:0] entries_q;
	logic                            cfg_wr;
	nbpcm_pkg::cmd_t                 cmd;
	nbpcm_pkg::status_t              status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_limit_q <= nbpcm_pkg::PAIR_LIMIT_RST;
			entries_q    <= nbpcm_pkg::ENTRIES_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				nbpcm_pkg::REG_PAIR_LIMIT: pair_limit_q <= pwdata[nbpcm_pkg::LIMIT_W-1:0];
				nbpcm_pkg::REG_ENTRIES:    entries_q    <= pwdata[nbpcm_pkg::ENTRIES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			nbpcm_pkg::REG_PAIR_LIMIT: prdata = 32'(pair_limit_q);
			nbpcm_pkg::REG_ENTRIES:    prdata = 32'(entries_q);
			default:                   prdata = '0;
		endcase
	end

	nbpcm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.entry_index    (entry_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entries_in_use (entries_q),
		.status         (status),
		.cmd            (cmd)
	);

	nbpcm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.entry_index   (entry_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.pair_limit_sq (pair_limit_q),
		.best_first    (best_first),
		.best_second   (best_second),
		.best_metric   (best_metric),
		.found         (found)
	);

endmodule

@@ sim/nearest_blended_pair_colour_match_unit_test.sv @@
`timescale 1ns / 1ps

module nearest_blended_pair_colour_match_unit_test;

	localparam int NUM_PHASES      = 16;
	localparam int ITEMS_PER_PHASE = 94;
	localparam int WATCHDOG_LIMIT  = 4000;

	typedef struct packed {
		logic [nbpcm_pkg::IDX_W-1:0]    first;
		logic [nbpcm_pkg::IDX_W-1:0]    second;
		logic [nbpcm_pkg::METRIC_W-1:0] metric;
		logic                           found;
	} match_result_t;

	class colour_match_scoreboard;
		logic [nbpcm_pkg::COLOUR_W-1:0]  colour_mem [nbpcm_pkg::MAX_ENTRIES];
		logic [nbpcm_pkg::LIMIT_W-1:0]   pair_limit;
		logic [nbpcm_pkg::ENTRIES_W-1:0] entries;
		match_result_t                   expected_q [$];
		int                              mismatches;
		int                              loads;
		int                              match_count;
		int                              misses;

		function new();
			pair_limit  = nbpcm_pkg::PAIR_LIMIT_RST;
			entries     = nbpcm_pkg::ENTRIES_RST;
			mismatches  = 0;
			loads       = 0;
			match_count = 0;
			misses      = 0;
		endfunction

		function int unsigned sq_diff(int unsigned a, int unsigned b);
			return (a > b) ? (a - b) * (a - b) : (b - a) * (b - a);
		endfunction

		function int unsigned redmean_score(int unsigned r1, int unsigned g1, int unsigned b1,
			int unsigned r2, int unsigned g2, int unsigned b2);
			int unsigned rm;
			rm = (r1 + r2) >> 1;
			return (((nbpcm_pkg::RED_BASE + rm) * sq_diff(r1, r2)) >> 8) + 4 * sq_diff(g1, g2)
				+ (((nbpcm_pkg::BLUE_BASE - rm) * sq_diff(b1, b2)) >> 8);
		endfunction

		// Scan ordered pairs; only a strictly smaller score displaces the best.
		function match_result_t best_pair(int unsigned tr, int unsigned tg, int unsigned tb);
			int unsigned   n;
			int unsigned   pd;
			int unsigned   score;
			int unsigned   best;
			int unsigned   r1, g1, b1, r2, g2, b2;
			match_result_t res;
			res  = '0;
			best = 0;
			n    = (entries > nbpcm_pkg::MAX_ENTRIES) ? nbpcm_pkg::MAX_ENTRIES : entries;
			for (int x = 0; x < n; x++) begin
				for (int y = 0; y < n; y++) begin
					r1 = colour_mem[x][23:16];
					g1 = colour_mem[x][15:8];
					b1 = colour_mem[x][7:0];
					r2 = colour_mem[y][23:16];
					g2 = colour_mem[y][15:8];
					b2 = colour_mem[y][7:0];
					pd = sq_diff(r1, r2) + sq_diff(g1, g2) + sq_diff(b1, b2);
					if (pd <= pair_limit) begin
						score = redmean_score((r1 + r2) >> 1, (g1 + g2) >> 1, (b1 + b2) >> 1,
							tr, tg, tb);
						if (!res.found || score < best) begin
							res.found  = 1'b1;
							res.first  = x[nbpcm_pkg::IDX_W-1:0];
							res.second = y[nbpcm_pkg::IDX_W-1:0];
							best       = score;
						end
					end
				end
			end
			res.metric = best[nbpcm_pkg::METRIC_W-1:0];
			return res;
		endfunction

		function void note_request(logic f, logic [nbpcm_pkg::IDX_W-1:0] idx,
			logic [nbpcm_pkg::CHAN_W-1:0] r, logic [nbpcm_pkg::CHAN_W-1:0] g,
			logic [nbpcm_pkg::CHAN_W-1:0] b);
			match_result_t res;
			if (f == nbpcm_pkg::FUNC_LOAD) begin
				colour_mem[idx] = {r, g, b};
				loads++;
			end else begin
				res = best_pair(r, g, b);
				expected_q = {expected_q, res};
				match_count++;
				if (!res.found)
					misses++;
			end
		endfunction

		function void check_result(match_result_t got);
			match_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no match request pending: first %0d second %0d metric %0d found %0d",
					got.first, got.second, got.metric, got.found);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			if (got.first !== want.first) begin
				$error("best_first: expected %0d, got %0d", want.first, got.first);
				mismatches++;
			end
			if (got.second !== want.second) begin
				$error("best_second: expected %0d, got %0d", want.second, got.second);
				mismatches++;
			end
			if (got.metric !== want.metric) begin
				$error("best_metric: expected %0d, got %0d", want.metric, got.metric);
				mismatches++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [2:0]                     paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_ready;
	logic                           func;
	logic [nbpcm_pkg::IDX_W-1:0]    entry_index;
	logic [nbpcm_pkg::CHAN_W-1:0]   red;
	logic [nbpcm_pkg::CHAN_W-1:0]   green;
	logic [nbpcm_pkg::CHAN_W-1:0]   blue;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [nbpcm_pkg::IDX_W-1:0]    best_first;
	logic [nbpcm_pkg::IDX_W-1:0]    best_second;
	logic [nbpcm_pkg::METRIC_W-1:0] best_metric;
	logic                           found;

	colour_match_scoreboard         sb;
	bit                             calm;
	logic [nbpcm_pkg::COLOUR_W-1:0] base_colour;
	int                             stall_left = 0;
	int                             idle_cycles = 0;
	int                             settings_seen;

	nearest_blended_pair_colour_match_unit dut (.*);

	always #2 clk = ~clk;

	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [nbpcm_pkg::CHAN_W-1:0] palette_chan();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128;
			3: return 8'd127;
			4: return 8'd1;
			default: return 8'd254;
		endcase
	endfunction

	function automatic logic [nbpcm_pkg::CHAN_W-1:0] near_chan(int c);
		int v;
		v = c + int'($urandom_range(0, 80)) - 40;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[nbpcm_pkg::CHAN_W-1:0];
	endfunction

	// Mix extremes, plain random and colours clustered near a phase base,
	// so that tight pair limits still let pairs through.
	task automatic pick_colour(output logic [nbpcm_pkg::CHAN_W-1:0] r,
		output logic [nbpcm_pkg::CHAN_W-1:0] g, output logic [nbpcm_pkg::CHAN_W-1:0] b);
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			r = palette_chan();
			g = palette_chan();
			b = palette_chan();
		end else if (mode < 6) begin
			{r, g, b} = 24'($urandom);
		end else begin
			r = near_chan(base_colour[23:16]);
			g = near_chan(base_colour[15:8]);
			b = near_chan(base_colour[7:0]);
		end
	endtask

	// Hold valid and payload until the request is taken.
	task automatic send_request(logic f, logic [nbpcm_pkg::IDX_W-1:0] idx,
		logic [nbpcm_pkg::CHAN_W-1:0] r, logic [nbpcm_pkg::CHAN_W-1:0] g,
		logic [nbpcm_pkg::CHAN_W-1:0] b);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		entry_index <= idx;
		red         <= r;
		green       <= g;
		blue        <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_request(f, idx, r, g, b);
	endtask

	// Drop valid, drain all results, then let a possible load finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == nbpcm_pkg::REG_PAIR_LIMIT)
			sb.pair_limit = value[nbpcm_pkg::LIMIT_W-1:0];
		else
			sb.entries = value[nbpcm_pkg::ENTRIES_W-1:0];
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({best_first, best_second, best_metric, found});
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [nbpcm_pkg::CHAN_W-1:0]    r, g, b;
		logic [nbpcm_pkg::LIMIT_W-1:0]   lim;
		logic [nbpcm_pkg::ENTRIES_W-1:0] ent;
		int                              pick;
		sb            = new();
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		func          = nbpcm_pkg::FUNC_LOAD;
		entry_index   = '0;
		red           = '0;
		green         = '0;
		blue          = '0;
		calm          = 1'b0;
		settings_seen = 1;
		base_colour   = 24'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole table first so no search ever reads an unwritten entry.
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd0, 8'h00, 8'h00, 8'h00);
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd1, 8'hff, 8'hff, 8'hff);
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd2, 8'hff, 8'h00, 8'h00);
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd3, 8'h00, 8'hff, 8'h00);
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd4, 8'h00, 8'h00, 8'hff);
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd5, 8'hff, 8'h00, 8'h00);
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd6, 8'h80, 8'h80, 8'h80);
		send_request(nbpcm_pkg::FUNC_LOAD, 4'd7, 8'h7f, 8'h7f, 8'h7f);
		for (int i = 8; i < nbpcm_pkg::MAX_ENTRIES; i++) begin
			pick_colour(r, g, b);
			send_request(nbpcm_pkg::FUNC_LOAD, i[nbpcm_pkg::IDX_W-1:0], r, g, b);
		end
		send_request(nbpcm_pkg::FUNC_MATCH, 4'd0, 8'h00, 8'h00, 8'h00);
		send_request(nbpcm_pkg::FUNC_MATCH, 4'd15, 8'hff, 8'hff, 8'hff);
		send_request(nbpcm_pkg::FUNC_MATCH, 4'd5, 8'hff, 8'h00, 8'h00);
		send_request(nbpcm_pkg::FUNC_MATCH, 4'd10, 8'h80, 8'h80, 8'h80);
		send_request(nbpcm_pkg::FUNC_MATCH, 4'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
					1: begin lim = '0; ent = 5'd16; end
					2: begin lim = '1; ent = 5'd31; end
					3: begin lim = 18'd195075; ent = 5'd0; end
					4: begin lim = nbpcm_pkg::PAIR_LIMIT_RST; ent = 5'd1; end
					5: begin lim = 18'($urandom); ent = 5'd17; end
					default: begin
						lim  = $urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(0, 20000));
						pick = $urandom_range(0, 19);
						if (pick < 12)
							ent = 5'($urandom_range(1, 6));
						else if (pick < 17)
							ent = 5'($urandom_range(7, 16));
						else if (pick < 19)
							ent = 5'($urandom_range(17, 31));
						else
							ent = 5'd0;
					end
				endcase
				write_register(nbpcm_pkg::REG_PAIR_LIMIT, {14'($urandom), lim});
				write_register(nbpcm_pkg::REG_ENTRIES, {27'($urandom), ent});
				settings_seen++;
			end
			calm        = (phase % 4 == 3);
			base_colour = 24'($urandom);
			repeat (ITEMS_PER_PHASE) begin
				pick_colour(r, g, b);
				if ($urandom_range(0, 99) < 55)
					send_request(nbpcm_pkg::FUNC_LOAD, 4'($urandom), r, g, b);
				else
					send_request(nbpcm_pkg::FUNC_MATCH, 4'($urandom), r, g, b);
			end
		end

		settle();
		repeat (16) @(posedge clk);
		$display("Run covered %0d table loads and %0d matches, %0d with no pair in range,",
			sb.loads, sb.match_count, sb.misses);
		$display("over %0d register settings incl. zero, full and saturated entry counts.",
			settings_seen);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/nbpcm_pkg.sv
hw/rtl/nbpcm_ram.sv
hw/rtl/nbpcm_ctrl.sv
hw/rtl/nbpcm_dp.sv
hw/rtl/nearest_blended_pair_colour_match_unit.sv
sim/nearest_blended_pair_colour_match_unit_test.sv
